[design/weighted_heading_mixer_macros.svh]
// Assertion helpers shared by the mixer RTL.
`ifndef WEIGHTED_HEADING_MIXER_MACROS_SVH
`define WEIGHTED_HEADING_MIXER_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define WHM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Plain invariant checked on every clock edge outside reset.
`define WHM_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

[design/whm_pkg.sv]
// ----------------------------------------------------------------------------
// whm_pkg
// Shared constants, register indexes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package whm_pkg;

  localparam int ANGLE_BITS_DEF       = 16;
  localparam int WEIGHT_FRAC_BITS_DEF = 15;
  localparam int CORDIC_STAGES_DEF    = 16;

  // Internal angle resolution (one turn = 2^32) and gain fraction bits.
  localparam int TURN_BITS = 32;
  localparam int ZW        = 35;
  localparam int GAIN_FRAC = 20;
  localparam int KW        = 21;
  localparam int TABLE_LEN = 24;

  typedef enum logic [1:0] {
    REG_MIN_WEIGHT_SUM   = 2'd0,
    REG_LIGHT_WEIGHT_SUM = 2'd1,
    REG_LOW_CONSENSUS    = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_GOOD     = 2'd0,
    ST_WEAK     = 2'd1,
    ST_REJECTED = 2'd2
  } status_t;

  localparam logic [31:0] ATAN_TURN32 [TABLE_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // Inverse squared CORDIC gain in Q20 after a given number of stages.
  function automatic logic [KW-1:0] inv_gain_sq(input int stages);
    logic [KW-1:0] k;
    begin
      if (stages <= 8) begin
        k = KW'(386680);
      end else if (stages == 9) begin
        k = KW'(386675);
      end else begin
        k = KW'(386674);
      end
      return k;
    end
  endfunction

endpackage

[design/whm_cordic_cell.sv]
// ----------------------------------------------------------------------------
// whm_cordic_cell
// One CORDIC micro-rotation, registered; rotation or vectoring mode.
// ----------------------------------------------------------------------------
module whm_cordic_cell #(
  parameter int IDX    = 0,
  parameter int XW     = 36,
  parameter bit VECTOR = 1'b0
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [XW-1:0]         x_i,
  input  logic signed [XW-1:0]         y_i,
  input  logic signed [whm_pkg::ZW-1:0] z_i,
  output logic signed [XW-1:0]         x_o,
  output logic signed [XW-1:0]         y_o,
  output logic signed [whm_pkg::ZW-1:0] z_o
);
  import whm_pkg::*;

  localparam logic signed [ZW-1:0] ATAN = ZW'(ATAN_TURN32[IDX]);

  logic signed [XW-1:0] xs, ys, x_nxt, y_nxt;
  logic signed [ZW-1:0] z_nxt;
  logic                 ccw;

  always_comb begin
    xs  = x_i >>> IDX;
    ys  = y_i >>> IDX;
    ccw = VECTOR ? y_i[XW-1] : ~z_i[ZW-1];
    if (ccw) begin
      x_nxt = x_i - ys;
      y_nxt = y_i + xs;
      z_nxt = z_i - ATAN;
    end else begin
      x_nxt = x_i + ys;
      y_nxt = y_i - xs;
      z_nxt = z_i + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_o <= x_nxt;
      y_o <= y_nxt;
      z_o <= z_nxt;
    end
  end

endmodule

[design/whm_div_cell.sv]
// ----------------------------------------------------------------------------
// whm_div_cell
// One restoring-division step: one quotient bit per cell, registered.
// ----------------------------------------------------------------------------
module whm_div_cell #(
  parameter int SUMW = 17,
  parameter int QW   = 16
) (
  input  logic            clk,
  input  logic            en,
  input  logic [SUMW-1:0] sw_i,
  input  logic [SUMW-1:0] rem_i,
  input  logic [QW-1:0]   mlow_i,
  input  logic [QW-1:0]   q_i,
  output logic [SUMW-1:0] rem_o,
  output logic [QW-1:0]   mlow_o,
  output logic [QW-1:0]   q_o
);
  import whm_pkg::*;

  logic [SUMW:0]   rem2, diff;
  logic            ge;
  logic [SUMW-1:0] rem_nxt;

  always_comb begin
    rem2    = {rem_i, mlow_i[QW-1]};
    diff    = rem2 - {1'b0, sw_i};
    ge      = rem2 >= {1'b0, sw_i};
    rem_nxt = ge ? diff[SUMW-1:0] : rem2[SUMW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o  <= rem_nxt;
      mlow_o <= {mlow_i[QW-2:0], 1'b0};
      q_o    <= {q_i[QW-2:0], ge};
    end
  end

endmodule

[design/weighted_heading_mixer.sv]
// ----------------------------------------------------------------------------
// weighted_heading_mixer
// Weighted circular mean of three headings with a consensus measure.
// ----------------------------------------------------------------------------
// Input channel (in_*): one item carries three headings with weights in
// tdata and their presence flags in tuser. Result channel (out_*): mixed
// heading and agreement in tdata, status (good, weak, rejected) in tuser.
// Configuration channel (cfg_*): register index and data, always ready;
// write only while no item is in flight.
// Each item runs through a chain of rotation cells (one per CORDIC stage,
// three lanes), a vector sum, a chain of vectoring cells, a gain multiply
// and a chain of division cells, one quotient bit per cell.
// Throughput: one item per cycle unless the output stalls; the whole chain
// advances together. When the receiver stalls with a result waiting, the
// chain holds and in_tready drops in the same cycle; nothing is dropped.
// Reset clears the valid bits of every stage and loads the register
// defaults (0.1, 0.5, 0.5 in weight units).
// ----------------------------------------------------------------------------
`include "weighted_heading_mixer_macros.svh"

module weighted_heading_mixer #(
  parameter int ANGLE_BITS       = whm_pkg::ANGLE_BITS_DEF,
  parameter int WEIGHT_FRAC_BITS = whm_pkg::WEIGHT_FRAC_BITS_DEF,
  parameter int CORDIC_STAGES    = whm_pkg::CORDIC_STAGES_DEF,
  localparam int LANEW = ANGLE_BITS + 2 + WEIGHT_FRAC_BITS + 1,
  localparam int INW   = ((3 * LANEW + 7) / 8) * 8,
  localparam int OUTW  = ((ANGLE_BITS + WEIGHT_FRAC_BITS + 1 + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // angle_a, weight_a, angle_b, weight_b, angle_c, weight_c (low bit up)
  input  logic [INW-1:0]                in_tdata,
  // valid_a, valid_b, valid_c (low bit up)
  input  logic [2:0]                    in_tuser,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // heading, agreement (low bit up)
  output logic [OUTW-1:0]               out_tdata,
  // status
  output logic [1:0]                    out_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [WEIGHT_FRAC_BITS+1:0]   cfg_data
);
  import whm_pkg::*;

  localparam int W     = WEIGHT_FRAC_BITS;
  localparam int N     = CORDIC_STAGES;
  localparam int AIW   = ANGLE_BITS + 2;
  localparam int WW    = W + 1;
  localparam int QW    = W + 1;
  localparam int SUMW  = W + 2;
  localparam int XW    = 2 * W + 6;
  localparam int SHIFT = TURN_BITS - ANGLE_BITS;
  localparam int MW    = XW + 2;
  localparam logic [KW-1:0] KINV = inv_gain_sq(N);
  localparam logic [WW-1:0] ONE_W = WW'(1) << W;
  localparam logic signed [ZW-1:0] HALF_TURN = ZW'(1) << (TURN_BITS - 1);

  logic adv;

  // configuration registers
  logic [SUMW-1:0] min_sum_r, light_sum_r;
  logic [QW-1:0]   low_cons_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_sum_r   <= SUMW'(3277);
      light_sum_r <= SUMW'(16384);
      low_cons_r  <= QW'(16384);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MIN_WEIGHT_SUM:   min_sum_r   <= cfg_data;
        REG_LIGHT_WEIGHT_SUM: light_sum_r <= cfg_data;
        REG_LOW_CONSENSUS:    low_cons_r  <= cfg_data[QW-1:0];
        default: ;
      endcase
    end
  end

  // input preparation: saturate weights, fold quadrants, build start vectors
  logic signed [XW-1:0] x0_nxt [3];
  logic signed [ZW-1:0] z0_nxt [3];
  logic [SUMW-1:0]      sw_nxt;

  always_comb begin
    logic [AIW-1:0] ang;
    logic [WW-1:0]  w;
    logic [31:0]    t;
    logic           flip;
    sw_nxt = '0;
    for (int l = 0; l < 3; l++) begin
      ang  = in_tdata[l*LANEW +: AIW];
      w    = in_tdata[l*LANEW + AIW +: WW];
      if (w > ONE_W) w = ONE_W;
      if (!in_tuser[l]) w = '0;
      sw_nxt = sw_nxt + SUMW'(w);
      t    = 32'(ang[ANGLE_BITS-1:0]) << SHIFT;
      flip = t[31] ^ t[30];
      x0_nxt[l] = XW'({w, {W{1'b0}}});
      if (flip) begin
        x0_nxt[l] = -x0_nxt[l];
        t[31]     = ~t[31];
      end
      z0_nxt[l] = ZW'(signed'(t));
    end
  end

  // rotation chain
  logic signed [XW-1:0] rx [N+1][3];
  logic signed [XW-1:0] ry [N+1][3];
  logic signed [ZW-1:0] rz [N+1][3];
  logic                 rv_r  [N+1];
  logic [SUMW-1:0]      rsw_r [N+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 3; l++) begin
        rx[0][l] <= x0_nxt[l];
        ry[0][l] <= '0;
        rz[0][l] <= z0_nxt[l];
      end
      rsw_r[0] <= sw_nxt;
      for (int s = 0; s < N; s++) rsw_r[s+1] <= rsw_r[s];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= N; s++) rv_r[s] <= 1'b0;
    end else if (adv) begin
      rv_r[0] <= in_tvalid;
      for (int s = 0; s < N; s++) rv_r[s+1] <= rv_r[s];
    end
  end

  for (genvar s = 0; s < N; s++) begin : g_rot
    for (genvar l = 0; l < 3; l++) begin : g_lane
      whm_cordic_cell #(.IDX(s), .XW(XW), .VECTOR(1'b0)) u_cell (
        .clk (clk),
        .en  (adv),
        .x_i (rx[s][l]),
        .y_i (ry[s][l]),
        .z_i (rz[s][l]),
        .x_o (rx[s+1][l]),
        .y_o (ry[s+1][l]),
        .z_o (rz[s+1][l])
      );
    end
  end

  // vector sum, fold into the right half plane
  logic signed [XW-1:0] vx [N+1];
  logic signed [XW-1:0] vy [N+1];
  logic signed [ZW-1:0] vz [N+1];
  logic                 vv_r    [N+1];
  logic [SUMW-1:0]      vsw_r   [N+1];
  logic                 vzero_r [N+1];
  logic signed [XW-1:0] sx, sy;

  assign sx = rx[N][0] + rx[N][1] + rx[N][2];
  assign sy = ry[N][0] + ry[N][1] + ry[N][2];

  always_ff @(posedge clk) begin
    if (adv) begin
      vx[0]      <= sx[XW-1] ? -sx : sx;
      vy[0]      <= sx[XW-1] ? -sy : sy;
      vz[0]      <= sx[XW-1] ? HALF_TURN : '0;
      vzero_r[0] <= (sx == '0) && (sy == '0);
      vsw_r[0]   <= rsw_r[N];
      for (int s = 0; s < N; s++) begin
        vsw_r[s+1]   <= vsw_r[s];
        vzero_r[s+1] <= vzero_r[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= N; s++) vv_r[s] <= 1'b0;
    end else if (adv) begin
      vv_r[0] <= rv_r[N];
      for (int s = 0; s < N; s++) vv_r[s+1] <= vv_r[s];
    end
  end

  for (genvar s = 0; s < N; s++) begin : g_vec
    whm_cordic_cell #(.IDX(s), .XW(XW), .VECTOR(1'b1)) u_cell (
      .clk (clk),
      .en  (adv),
      .x_i (vx[s]),
      .y_i (vy[s]),
      .z_i (vz[s]),
      .x_o (vx[s+1]),
      .y_o (vy[s+1]),
      .z_o (vz[s+1])
    );
  end

  // gain correction: two partial products, then their sum
  logic [XW-1:0]           mag;
  logic [31:0]             hsum;
  logic [ANGLE_BITS-1:0]   head_nxt;
  logic [XW-GAIN_FRAC+KW-1:0] hi_prod_r;
  logic [GAIN_FRAC+KW-1:0]    lo_prod_r;
  logic [ANGLE_BITS-1:0]   p1_head_r, p2_head_r;
  logic [SUMW-1:0]         p1_sw_r, p2_sw_r;
  logic                    p1_v_r, p2_v_r;
  logic [MW-1:0]           m_r;

  always_comb begin
    mag      = (vzero_r[N] || vx[N][XW-1]) ? '0 : vx[N];
    hsum     = vz[N][31:0] + (32'd1 << (SHIFT - 1));
    head_nxt = vzero_r[N] ? '0 : hsum[31:SHIFT];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hi_prod_r <= mag[XW-1:GAIN_FRAC] * KINV;
      lo_prod_r <= mag[GAIN_FRAC-1:0] * KINV;
      p1_head_r <= head_nxt;
      p1_sw_r   <= vsw_r[N];
      m_r       <= MW'(hi_prod_r) + MW'(lo_prod_r >> GAIN_FRAC);
      p2_head_r <= p1_head_r;
      p2_sw_r   <= p1_sw_r;
    end
  end

  // division chain: m / sw, clipped above one
  logic [SUMW-1:0]       dsw_r  [QW+1];
  logic [ANGLE_BITS-1:0] dhd_r  [QW+1];
  logic                  dsat_r [QW+1];
  logic                  dv_r   [QW+1];
  logic [SUMW-1:0]       drem [QW+1];
  logic [QW-1:0]         dml  [QW+1];
  logic [QW-1:0]         dq   [QW+1];
  logic [MW-1:0]         m_hi;

  assign m_hi = m_r >> QW;

  always_ff @(posedge clk) begin
    if (adv) begin
      dsat_r[0] <= m_r >= (MW'(p2_sw_r) << QW);
      drem[0]   <= m_hi[SUMW-1:0];
      dml[0]    <= m_r[QW-1:0];
      dq[0]     <= '0;
      dsw_r[0]  <= p2_sw_r;
      dhd_r[0]  <= p2_head_r;
      for (int s = 0; s < QW; s++) begin
        dsw_r[s+1]  <= dsw_r[s];
        dhd_r[s+1]  <= dhd_r[s];
        dsat_r[s+1] <= dsat_r[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
      for (int s = 0; s <= QW; s++) dv_r[s] <= 1'b0;
    end else if (adv) begin
      p1_v_r  <= vv_r[N];
      p2_v_r  <= p1_v_r;
      dv_r[0] <= p2_v_r;
      for (int s = 0; s < QW; s++) dv_r[s+1] <= dv_r[s];
    end
  end

  for (genvar s = 0; s < QW; s++) begin : g_div
    whm_div_cell #(.SUMW(SUMW), .QW(QW)) u_cell (
      .clk    (clk),
      .en     (adv),
      .sw_i   (dsw_r[s]),
      .rem_i  (drem[s]),
      .mlow_i (dml[s]),
      .q_i    (dq[s]),
      .rem_o  (drem[s+1]),
      .mlow_o (dml[s+1]),
      .q_o    (dq[s+1])
    );
  end

  // status decision and output register
  logic [QW-1:0]         cons, agree_nxt;
  logic [ANGLE_BITS-1:0] head_out;
  status_t               stat_nxt;
  logic [SUMW-1:0]       fsw;
  logic                  out_valid_r;
  logic [ANGLE_BITS-1:0] out_head_r;
  logic [QW-1:0]         out_agree_r;
  status_t               out_stat_r;

  always_comb begin
    fsw  = dsw_r[QW];
    cons = (dsat_r[QW] || dq[QW] > ONE_W) ? ONE_W : dq[QW];
    head_out  = dhd_r[QW];
    agree_nxt = cons;
    stat_nxt  = ST_GOOD;
    if (fsw == '0 || fsw < min_sum_r) begin
      head_out  = '0;
      agree_nxt = '0;
      stat_nxt  = ST_REJECTED;
    end else if (fsw < light_sum_r || cons < low_cons_r) begin
      stat_nxt = ST_WEAK;
      if (fsw < SUMW'(cons)) agree_nxt = fsw[QW-1:0];
    end
  end

  assign adv = !out_valid_r || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_head_r  <= head_out;
      out_agree_r <= agree_nxt;
      out_stat_r  <= stat_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUTW'({out_agree_r, out_head_r});
  assign out_tuser  = out_stat_r;

  `WHM_ASSERT_IMPL(a_reject_zero, out_tvalid && out_tuser == ST_REJECTED, out_tdata == '0, "rejected item carries data")
  `WHM_ASSERT_IMPL(a_agree_max, out_tvalid, out_agree_r <= ONE_W, "agreement above one")
  `WHM_ASSERT_IMPL(a_stall_hold, out_tvalid && !out_tready, !in_tready, "input taken while output stalled")

endmodule

[tb/tb_weighted_heading_mixer.sv]
// ----------------------------------------------------------------------------
// tb_weighted_heading_mixer
// Self-checking bench for the three-heading weighted circular mean.
// Items run through a bursty driver and a stalling receiver. Every result
// is checked against a bit-exact CORDIC predictor that uses the register
// values current at input time. Several register settings are covered.
// ----------------------------------------------------------------------------
module tb_weighted_heading_mixer;
  import whm_pkg::*;

  localparam int NSTG   = CORDIC_STAGES_DEF;
  localparam int LIMIT  = 400000;
  localparam int LATENCY = 2 * NSTG + WEIGHT_FRAC_BITS_DEF + 6;

  typedef struct packed {
    logic [2:0][17:0] angle;
    logic [2:0][15:0] weight;
    logic [2:0]       present;
  } heading_item_t;

  typedef struct packed {
    logic [15:0] heading;
    logic [15:0] agreement;
    logic [1:0]  status;
  } mix_result_t;

  logic         clk;
  logic         rst_n;
  logic [103:0] in_tdata;
  logic [2:0]   in_tuser;
  logic         in_tvalid;
  logic         in_tready;
  logic [31:0]  out_tdata;
  logic [1:0]   out_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [1:0]   cfg_index;
  logic [16:0]  cfg_data;

  weighted_heading_mixer u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tuser(in_tuser), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  heading_item_t pending_items[$];
  mix_result_t   expected_mix[$];
  logic [16:0]   min_sum_q, light_sum_q;
  logic [15:0]   low_cons_q;
  logic          in_took;
  int            errors, n_results, n_rejected, n_weak, cycles;
  int            burst_left, gap_left, long_hold;

  function automatic mix_result_t mix_predict(heading_item_t it);
    longint sx, sy, x, y, z, nx, ny;
    longint unsigned sw, w, mag, m, c, k;
    logic [31:0] t;
    mix_result_t r;
    sx = 0; sy = 0; sw = 0;
    for (int n = 0; n < 3; n++) begin
      w = it.weight[n];
      if (w > 32768) w = 32768;
      if (!it.present[n]) w = 0;
      sw += w;
      t = {it.angle[n][15:0], 16'h0};
      x = longint'(w << 15);
      y = 0;
      if (t[31:30] == 2'd1 || t[31:30] == 2'd2) begin
        x = -x;
        t = t + 32'h8000_0000;
      end
      z = longint'($signed(t));
      for (int i = 0; i < NSTG; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i); ny = y + (x >>> i); z -= longint'(ATAN_TURN32[i]);
        end else begin
          nx = x + (y >>> i); ny = y - (x >>> i); z += longint'(ATAN_TURN32[i]);
        end
        x = nx; y = ny;
      end
      sx += x; sy += y;
    end
    r = '0;
    if (sw == 0 || sw < min_sum_q) begin
      r.status = ST_REJECTED;
      return r;
    end
    mag = 0;
    if (sx != 0 || sy != 0) begin
      x = sx; y = sy; z = 0;
      if (x < 0) begin
        x = -x; y = -y; z = 64'sd1 << 31;
      end
      for (int i = 0; i < NSTG; i++) begin
        if (y >= 0) begin
          nx = x + (y >>> i); ny = y - (x >>> i); z += longint'(ATAN_TURN32[i]);
        end else begin
          nx = x - (y >>> i); ny = y + (x >>> i); z -= longint'(ATAN_TURN32[i]);
        end
        x = nx; y = ny;
      end
      mag = x > 0 ? longint'(x) : 0;
      r.heading = 16'((((z & 64'hFFFF_FFFF) + 64'd32768) >> 16));
    end
    k = 64'd1 << 20;
    for (int i = 0; i < NSTG; i++) k -= k / ((64'd1 << (2 * i)) + 1);
    m = (mag >> 20) * k + (((mag & 64'hF_FFFF) * k) >> 20);
    c = m / sw;
    if (c > 32768) c = 32768;
    r.status = ST_GOOD;
    if (sw < light_sum_q || c < low_cons_q) begin
      r.status = ST_WEAK;
      if (sw < c) c = sw;
    end
    r.agreement = c[15:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want, n_results);
    errors++;
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // monitor: register copy, result check, prediction on input accept
  always @(posedge clk) begin
    mix_result_t e;
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("weighted_heading_mixer test failed");
      $finish;
    end
    in_took <= in_tvalid && in_tready;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MIN_WEIGHT_SUM:   min_sum_q = cfg_data;
          REG_LIGHT_WEIGHT_SUM: light_sum_q = cfg_data;
          REG_LOW_CONSENSUS:    low_cons_q = cfg_data[15:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (expected_mix.size() == 0) begin
          $display("MISMATCH unexpected result %h/%0d", out_tdata, out_tuser);
          errors++;
        end else begin
          e = expected_mix.pop_front();
          if (out_tdata[15:0] !== e.heading) report_mismatch("heading", out_tdata[15:0], e.heading);
          if (out_tdata[31:16] !== e.agreement)
            report_mismatch("agreement", out_tdata[31:16], e.agreement);
          if (out_tuser !== e.status) report_mismatch("status", out_tuser, e.status);
          if (e.status == ST_REJECTED) n_rejected++;
          if (e.status == ST_WEAK) n_weak++;
        end
        n_results++;
      end
      if (in_tvalid && in_tready) begin
        e = mix_predict({in_tdata[85:68], in_tdata[51:34], in_tdata[17:0],
                         in_tdata[101:86], in_tdata[67:52], in_tdata[33:18],
                         in_tuser[2], in_tuser[1], in_tuser[0]});
        expected_mix.push_back(e);
      end
    end
  end

  // driver: bursts with random gaps, hold until accepted
  always @(negedge clk) begin
    heading_item_t it;
    if (rst_n && !(in_tvalid && !in_took)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        it = pending_items.pop_front();
        in_tdata <= {2'b0, it.weight[2], it.angle[2], it.weight[1], it.angle[1],
                     it.weight[0], it.angle[0]};
        in_tuser <= it.present;
        in_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern that changes mode, plus one long hold-off
  always @(negedge clk) begin
    int mode;
    logic rdy;
    if (rst_n) begin
      if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 3);
      if (long_hold > 0) begin
        long_hold--;
        rdy = 1'b0;
      end else begin
        case (mode)
          0: rdy = 1'b1;
          1: rdy = $urandom_range(0, 1);
          2: rdy = ($urandom_range(0, 4) == 0);
          default: rdy = ($urandom_range(0, 7) != 0);
        endcase
      end
      out_tready <= rdy;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input int val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[16:0];
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain;
    while (pending_items.size() > 0 || expected_mix.size() > 0 || in_tvalid) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic push_item(input int a0, input int w0, input int a1, input int w1,
                           input int a2, input int w2, input logic [2:0] pr);
    heading_item_t it;
    it.angle[0] = a0[17:0]; it.angle[1] = a1[17:0]; it.angle[2] = a2[17:0];
    it.weight[0] = w0[15:0]; it.weight[1] = w1[15:0]; it.weight[2] = w2[15:0];
    it.present = pr;
    pending_items.push_back(it);
  endtask

  function automatic int rand_angle();
    case ($urandom_range(0, 3))
      0: return int'($urandom_range(0, 98304)) - 32768;
      1: return int'($urandom() & 32'h3FFFF);
      default: return int'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic int rand_weight();
    case ($urandom_range(0, 7))
      0: return $urandom() & 32'hFFFF;
      1: return $urandom_range(0, 4000);
      2: return 32768;
      default: return $urandom_range(0, 32768);
    endcase
  endfunction

  task automatic random_items(input int count);
    int base, spread;
    logic [2:0] pr;
    for (int i = 0; i < count; i++) begin
      pr = ($urandom_range(0, 3) == 0) ? 3'($urandom()) : 3'b111;
      if ($urandom_range(0, 2) != 0) begin
        // headings clustered around a common direction
        base = $urandom_range(0, 65535);
        spread = 1 << $urandom_range(0, 15);
        push_item(base + $urandom_range(0, spread), rand_weight(),
                  base - $urandom_range(0, spread), rand_weight(),
                  base + 65536 * $urandom_range(0, 1) - $urandom_range(0, spread) / 2,
                  rand_weight(), pr);
      end else begin
        push_item(rand_angle(), rand_weight(), rand_angle(), rand_weight(),
                  rand_angle(), rand_weight(), pr);
      end
    end
  endtask

  initial begin
    int setting[4][3];
    rst_n = 0;
    in_tdata = '0; in_tuser = '0; in_tvalid = 0;
    out_tready = 0;
    cfg_valid = 0; cfg_index = '0; cfg_data = '0;
    min_sum_q = 17'd3277; light_sum_q = 17'd16384; low_cons_q = 16'd16384;
    in_took = 0;
    errors = 0; n_results = 0; n_rejected = 0; n_weak = 0; cycles = 0;
    burst_left = 1; gap_left = 0; long_hold = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // defaults, directed corners
    push_item(0, 32768, 0, 32768, 0, 32768, 3'b111);
    push_item(0, 0, 0, 0, 0, 0, 3'b111);
    push_item(100, 32768, 200, 32768, 300, 32768, 3'b000);
    push_item(0, 32768, 32768, 32768, 0, 0, 3'b011);
    push_item(0, 32768, 21845, 32768, 43691, 32768, 3'b111);
    push_item(-32768, 65535, 65536, 40000, 131071, 32769, 3'b111);
    push_item(-131072, 1000, 65535, 1000, 1, 1000, 3'b111);
    push_item(16384, 3276, 0, 0, 0, 0, 3'b001);
    push_item(16384, 3277, 0, 0, 0, 0, 3'b001);
    push_item(49152, 16383, 49152, 1, 0, 0, 3'b011);
    push_item(8192, 32768, 24576, 32768, 0, 0, 3'b011);
    push_item(65535, 32768, 1, 32768, 32767, 100, 3'b111);
    push_item(32767, 20000, 32768, 20000, 32769, 20000, 3'b111);
    push_item(-1, 32768, 0, 32768, 0, 32768, 3'b101);
    push_item(12345, 65535, 54321, 65535, 777, 65535, 3'b110);
    push_item(40000, 32768, 40000, 32768, 40000, 32768, 3'b010);
    drain();

    setting = '{'{3277, 16384, 16384}, '{0, 0, 0},
                '{98304, 98304, 32768}, '{131071, 131071, 65535}};
    for (int p = 0; p < 6; p++) begin
      if (p < 4) begin
        write_reg(REG_MIN_WEIGHT_SUM, setting[p][0]);
        write_reg(REG_LIGHT_WEIGHT_SUM, setting[p][1]);
        write_reg(REG_LOW_CONSENSUS, setting[p][2]);
      end else begin
        write_reg(REG_MIN_WEIGHT_SUM, $urandom_range(0, 20000));
        write_reg(REG_LIGHT_WEIGHT_SUM, $urandom_range(0, 98304));
        write_reg(REG_LOW_CONSENSUS, $urandom_range(0, 32768));
        write_reg(2'd3, $urandom());
      end
      if (p == 1) long_hold = 400;
      random_items(p == 0 ? 250 : 140);
      drain();
    end

    repeat (LATENCY + 10) @(posedge clk);
    $display("covered %0d results over 7 register settings: %0d weak, %0d rejected",
             n_results, n_weak, n_rejected);
    if (errors == 0 && expected_mix.size() == 0) begin
      $display("weighted_heading_mixer test passed");
    end else begin
      $display("%0d mismatches, %0d results still expected", errors, expected_mix.size());
      $display("weighted_heading_mixer test failed");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+design
design/whm_pkg.sv
design/whm_cordic_cell.sv
design/whm_div_cell.sv
design/weighted_heading_mixer.sv
tb/tb_weighted_heading_mixer.sv
